// File: rtl/nbg_pkg.sv
// Shared types, codes and saturation helpers for the 2D n-body step unit.
`default_nettype none
package nbg_pkg;

  localparam int PROD_W  = 97;
  localparam int DEN_W   = 66;
  localparam int MCAND_W = 64;
  localparam int MPLR_W  = 33;

  localparam logic [1:0] CMD_ADD   = 2'd0;
  localparam logic [1:0] CMD_CLEAR = 2'd1;
  localparam logic [1:0] CMD_STEP  = 2'd2;

  localparam logic [2:0] ST_ADDED     = 3'd0;
  localparam logic [2:0] ST_FULL      = 3'd1;
  localparam logic [2:0] ST_ZERO_MASS = 3'd2;
  localparam logic [2:0] ST_CLEARED   = 3'd3;
  localparam logic [2:0] ST_BODY      = 3'd4;

  localparam logic [15:0] COUPLING_RST = 16'd6554;

  localparam logic [62:0] TERM_CAP = 63'h4000_0000_0000_0000;
  localparam logic [62:0] DV_CAP   = 63'h0000_0100_0000_0000;

  typedef enum logic [3:0] {
    S_IDLE, S_RD_I, S_LAT_I, S_RD_J, S_LAT_J, S_RUN_GO, S_RUN_WAIT,
    S_FIN_I, S_WR_I, S_CM_RD, S_CM_WR
  } state_t;

  typedef enum logic [3:0] {
    OP_SQX, OP_SQY, OP_MM, OP_MC, OP_NX, OP_DX, OP_NY, OP_DY,
    OP_FX, OP_VX, OP_FY, OP_VY, OP_PX, OP_PY
  } op_t;

  typedef struct packed {
    logic start;
    logic is_div;
    logic cap_dv;
  } unit_req_t;

  function automatic logic [63:0] sat62_add(input logic signed [63:0] acc,
                                            input logic [62:0] mag, input logic neg);
    logic signed [64:0] m;
    logic signed [64:0] s;
    logic signed [64:0] hi;
    logic signed [64:0] lo;
    m  = signed'({2'b00, mag});
    hi = signed'({2'b00, TERM_CAP});
    lo = -hi;
    s  = {acc[63], acc} + (neg ? -m : m);
    if (s > hi) begin
      return hi[63:0];
    end else if (s < lo) begin
      return lo[63:0];
    end
    return s[63:0];
  endfunction

  function automatic logic [31:0] sat32_add(input logic signed [31:0] base,
                                            input logic [56:0] mag, input logic neg);
    logic signed [58:0] m;
    logic signed [58:0] s;
    m = signed'({2'b00, mag});
    s = {{27{base[31]}}, base} + (neg ? -m : m);
    if (s > 59'sd2147483647) begin
      return 32'h7fff_ffff;
    end else if (s < -59'sd2147483648) begin
      return 32'h8000_0000;
    end
    return s[31:0];
  endfunction

endpackage
`default_nettype wire

// File: rtl/nbg_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module nbg_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: rtl/nbg_arith.sv
// Shared bit-serial multiplier and restoring divider with capped quotient.
`default_nettype none
module nbg_arith (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire nbg_pkg::unit_req_t               req,
  input  wire logic [nbg_pkg::PROD_W-1:0]       a,
  input  wire logic [nbg_pkg::DEN_W-1:0]        b,
  output logic                                  done,
  output logic      [nbg_pkg::PROD_W-1:0]       res
);

  localparam logic [6:0] MUL_STEPS = 7'(nbg_pkg::MPLR_W - 1);
  localparam logic [6:0] DIV_STEPS = 7'(nbg_pkg::PROD_W - 1);
  localparam int HI_W = nbg_pkg::PROD_W - nbg_pkg::MPLR_W;

  logic                         run;
  logic                         is_div;
  logic                         cap_dv;
  logic                         den_zero;
  logic [6:0]                   cnt;
  logic [nbg_pkg::DEN_W-1:0]    opnd;
  logic [nbg_pkg::PROD_W-1:0]   acc;
  logic [nbg_pkg::DEN_W-1:0]    rem;

  logic [HI_W:0]                msum;
  logic [nbg_pkg::DEN_W:0]      sh;
  logic [nbg_pkg::DEN_W:0]      diff;
  logic                         ge;
  logic [62:0]                  cap;

  assign msum = {1'b0, acc[nbg_pkg::PROD_W-1:nbg_pkg::MPLR_W]}
              + (acc[0] ? {1'b0, opnd[nbg_pkg::MCAND_W-1:0]} : '0);
  assign sh   = {rem, acc[nbg_pkg::PROD_W-1]};
  assign ge   = sh >= {1'b0, opnd};
  assign diff = sh - {1'b0, opnd};
  assign cap  = cap_dv ? nbg_pkg::DV_CAP : nbg_pkg::TERM_CAP;

  always_comb begin
    if (!is_div) begin
      res = acc;
    end else if (den_zero) begin
      res = '0;
    end else if (acc > nbg_pkg::PROD_W'(cap)) begin
      res = nbg_pkg::PROD_W'(cap);
    end else begin
      res = acc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        run <= 1'b1;
        cnt <= req.is_div ? DIV_STEPS : MUL_STEPS;
      end else if (run) begin
        if (cnt == '0) begin
          run  <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 7'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      is_div   <= req.is_div;
      cap_dv   <= req.cap_dv;
      den_zero <= (b == '0);
      rem      <= '0;
      if (req.is_div) begin
        opnd <= b;
        acc  <= a;
      end else begin
        opnd <= nbg_pkg::DEN_W'(a[nbg_pkg::MCAND_W-1:0]);
        acc  <= nbg_pkg::PROD_W'(b[nbg_pkg::MPLR_W-1:0]);
      end
    end else if (run) begin
      if (is_div) begin
        rem <= ge ? diff[nbg_pkg::DEN_W-1:0] : sh[nbg_pkg::DEN_W-1:0];
        acc <= {acc[nbg_pkg::PROD_W-2:0], ge};
      end else begin
        acc <= {msum, acc[nbg_pkg::MPLR_W-1:1]};
      end
    end
  end

  a_done_after_run: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(run)) else $error("done without a running operation");
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    req.start |-> !run) else $error("start while unit busy");
  a_single_done: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("done held longer than one cycle");

endmodule
`default_nettype wire

// File: rtl/nbody_gravity_step_2d_unit.sv
// Top level: 2D direct-sum n-body table with add, clear and step commands.
// Add and clear: one result in the cycle after the request, ready again at once.
// Step over N bodies: every multiply and 97-bit divide goes through the shared
// serial unit, one operation at a time.
// Step results leave at its end, one per body, each read in S_CM_RD and sent in S_CM_WR; the receiver cannot stall.
// Reset clears the body count and sets coupling to 0.1; table RAMs are not cleared.
`default_nettype none
module nbody_gravity_step_2d_unit #(
  parameter int MAX_BODIES = 64,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [1:0]         command,
  input  wire logic signed [31:0] pos_x,
  input  wire logic signed [31:0] pos_y,
  input  wire logic signed [31:0] vel_x,
  input  wire logic signed [31:0] vel_y,
  input  wire logic [31:0]        body_mass,
  input  wire logic               is_fixed,
  input  wire logic [23:0]        time_step,
  input  wire logic               cfg_we,
  input  wire logic [15:0]        cfg_wdata,
  output logic                    result_valid,
  output logic [2:0]              status,
  output logic [5:0]              body_index,
  output logic signed [31:0]      out_pos_x,
  output logic signed [31:0]      out_pos_y,
  output logic signed [31:0]      out_vel_x,
  output logic signed [31:0]      out_vel_y,
  output logic [6:0]              body_count,
  output logic                    last
);

  localparam int IDX_W = $clog2(MAX_BODIES);
  localparam int CNT_W = $clog2(MAX_BODIES + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_BODIES);

  nbg_pkg::state_t state, state_next;
  nbg_pkg::op_t    op, op_next;

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] i;
  logic [CNT_W-1:0] j;
  logic [15:0]      coupling;
  logic [23:0]      treg;

  logic signed [31:0] pix, piy, vix, viy;
  logic [31:0]        mi, mj;
  logic               fix_i;
  logic [32:0]        ax, ay;
  logic               sgx, sgy;
  logic [65:0]        d2;
  logic [63:0]        c;
  logic [96:0]        num;
  logic signed [63:0] fx, fy;
  logic signed [31:0] vnx, vny, pnx, pny;

  logic               accept;
  logic               add_ok;
  logic               i_last;
  logic [65:0]        d2_sum;
  logic signed [32:0] dx, dy;
  logic signed [32:0] sx, sy;
  logic [63:0]        fx_neg, fy_neg;
  logic [62:0]        fx_mag, fy_mag;
  logic [32:0]        sx_mag, sy_mag;
  logic [56:0]        dp;

  nbg_pkg::unit_req_t u_req;
  logic [96:0]        u_a;
  logic [65:0]        u_b;
  logic               u_done;
  logic [96:0]        u_res;

  logic               st_we;
  logic [IDX_W-1:0]   st_waddr, st_raddr;
  logic [127:0]       st_wdata, st_rdata;
  logic               at_we;
  logic [IDX_W-1:0]   at_waddr, at_raddr;
  logic [32:0]        at_wdata, at_rdata;
  logic               sg_we;
  logic [IDX_W-1:0]   sg_waddr, sg_raddr;
  logic [127:0]       sg_wdata, sg_rdata;

  assign busy   = (state != nbg_pkg::S_IDLE);
  assign accept = start && !busy;
  assign add_ok = (command == nbg_pkg::CMD_ADD) && (count != CNT_MAX) && (body_mass != '0);
  assign i_last = (i + CNT_W'(1)) == count;
  assign d2_sum = d2 + u_res[65:0];

  assign dx     = {st_rdata[127], st_rdata[127:96]} - {pix[31], pix};
  assign dy     = {st_rdata[95], st_rdata[95:64]} - {piy[31], piy};
  assign fx_neg = -fx;
  assign fy_neg = -fy;
  assign fx_mag = fx[63] ? fx_neg[62:0] : fx[62:0];
  assign fy_mag = fy[63] ? fy_neg[62:0] : fy[62:0];
  assign sx     = {vnx[31], vnx} + {vix[31], vix};
  assign sy     = {vny[31], vny} + {viy[31], viy};
  assign sx_mag = sx[32] ? 33'(-sx) : 33'(sx);
  assign sy_mag = sy[32] ? 33'(-sy) : 33'(sy);
  assign dp     = u_res[56:0] >> (FRAC_BITS + 1);

  always_comb begin
    case (op)
      nbg_pkg::OP_SQX: op_next = nbg_pkg::OP_SQY;
      nbg_pkg::OP_SQY: op_next = nbg_pkg::OP_MM;
      nbg_pkg::OP_MM:  op_next = nbg_pkg::OP_MC;
      nbg_pkg::OP_MC:  op_next = nbg_pkg::OP_NX;
      nbg_pkg::OP_NX:  op_next = nbg_pkg::OP_DX;
      nbg_pkg::OP_DX:  op_next = nbg_pkg::OP_NY;
      nbg_pkg::OP_NY:  op_next = nbg_pkg::OP_DY;
      nbg_pkg::OP_FX:  op_next = nbg_pkg::OP_VX;
      nbg_pkg::OP_VX:  op_next = nbg_pkg::OP_FY;
      nbg_pkg::OP_FY:  op_next = nbg_pkg::OP_VY;
      nbg_pkg::OP_VY:  op_next = nbg_pkg::OP_PX;
      nbg_pkg::OP_PX:  op_next = nbg_pkg::OP_PY;
      default:         op_next = op;
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      nbg_pkg::S_IDLE: begin
        if (accept && command == nbg_pkg::CMD_STEP && count != '0) begin
          state_next = nbg_pkg::S_RD_I;
        end
      end
      nbg_pkg::S_RD_I:  state_next = nbg_pkg::S_LAT_I;
      nbg_pkg::S_LAT_I: state_next = nbg_pkg::S_RD_J;
      nbg_pkg::S_RD_J: begin
        if (j == count) begin
          state_next = nbg_pkg::S_FIN_I;
        end else if (j != i) begin
          state_next = nbg_pkg::S_LAT_J;
        end
      end
      nbg_pkg::S_LAT_J:  state_next = nbg_pkg::S_RUN_GO;
      nbg_pkg::S_RUN_GO: state_next = nbg_pkg::S_RUN_WAIT;
      nbg_pkg::S_RUN_WAIT: begin
        if (u_done) begin
          if ((op == nbg_pkg::OP_SQY && d2_sum == '0) || op == nbg_pkg::OP_DY) begin
            state_next = nbg_pkg::S_RD_J;
          end else if (op == nbg_pkg::OP_PY) begin
            state_next = nbg_pkg::S_WR_I;
          end else begin
            state_next = nbg_pkg::S_RUN_GO;
          end
        end
      end
      nbg_pkg::S_FIN_I: state_next = fix_i ? nbg_pkg::S_WR_I : nbg_pkg::S_RUN_GO;
      nbg_pkg::S_WR_I:  state_next = i_last ? nbg_pkg::S_CM_RD : nbg_pkg::S_RD_I;
      nbg_pkg::S_CM_RD: state_next = nbg_pkg::S_CM_WR;
      nbg_pkg::S_CM_WR: state_next = i_last ? nbg_pkg::S_IDLE : nbg_pkg::S_CM_RD;
      default:          state_next = nbg_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    st_raddr = (state == nbg_pkg::S_RD_J) ? j[IDX_W-1:0] : i[IDX_W-1:0];
    at_raddr = st_raddr;
    sg_raddr = i[IDX_W-1:0];

    st_we    = (accept && add_ok) || (state == nbg_pkg::S_CM_WR);
    st_waddr = (state == nbg_pkg::S_CM_WR) ? i[IDX_W-1:0] : count[IDX_W-1:0];
    st_wdata = (state == nbg_pkg::S_CM_WR) ? sg_rdata : {pos_x, pos_y, vel_x, vel_y};
    at_we    = accept && add_ok;
    at_waddr = count[IDX_W-1:0];
    at_wdata = {body_mass, is_fixed};
    sg_we    = (state == nbg_pkg::S_WR_I);
    sg_waddr = i[IDX_W-1:0];
    sg_wdata = {pnx, pny, vnx, vny};

    u_req = '0;
    u_a   = '0;
    u_b   = '0;
    if (state == nbg_pkg::S_RUN_GO) begin
      u_req.start = 1'b1;
      case (op)
        nbg_pkg::OP_SQX: begin u_a = 97'(ax); u_b = 66'(ax); end
        nbg_pkg::OP_SQY: begin u_a = 97'(ay); u_b = 66'(ay); end
        nbg_pkg::OP_MM:  begin u_a = 97'(mi); u_b = 66'(mj); end
        nbg_pkg::OP_MC:  begin u_a = 97'(c); u_b = 66'(coupling); end
        nbg_pkg::OP_NX:  begin u_a = 97'(c); u_b = 66'(ax); end
        nbg_pkg::OP_NY:  begin u_a = 97'(c); u_b = 66'(ay); end
        nbg_pkg::OP_DX, nbg_pkg::OP_DY: begin
          u_req.is_div = 1'b1;
          u_a = num;
          u_b = d2;
        end
        nbg_pkg::OP_FX:  begin u_a = 97'(fx_mag); u_b = 66'(treg); end
        nbg_pkg::OP_FY:  begin u_a = 97'(fy_mag); u_b = 66'(treg); end
        nbg_pkg::OP_VX, nbg_pkg::OP_VY: begin
          u_req.is_div = 1'b1;
          u_req.cap_dv = 1'b1;
          u_a = num;
          u_b = 66'(mi);
        end
        nbg_pkg::OP_PX:  begin u_a = 97'(sx_mag); u_b = 66'(treg); end
        nbg_pkg::OP_PY:  begin u_a = 97'(sy_mag); u_b = 66'(treg); end
        default: begin u_a = '0; u_b = '0; end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= nbg_pkg::S_IDLE;
      op           <= nbg_pkg::OP_SQX;
      count        <= '0;
      i            <= '0;
      j            <= '0;
      coupling     <= nbg_pkg::COUPLING_RST;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= (accept && (command == nbg_pkg::CMD_ADD || command == nbg_pkg::CMD_CLEAR))
                      || (state == nbg_pkg::S_CM_WR);
      if (cfg_we) begin
        coupling <= cfg_wdata;
      end
      if (accept && add_ok) begin
        count <= count + CNT_W'(1);
      end else if (accept && command == nbg_pkg::CMD_CLEAR) begin
        count <= '0;
      end
      case (state)
        nbg_pkg::S_IDLE:  i <= '0;
        nbg_pkg::S_LAT_I: j <= '0;
        nbg_pkg::S_RD_J: begin
          if (j != count && j == i) begin
            j <= j + CNT_W'(1);
          end
        end
        nbg_pkg::S_LAT_J: op <= nbg_pkg::OP_SQX;
        nbg_pkg::S_FIN_I: op <= nbg_pkg::OP_FX;
        nbg_pkg::S_RUN_WAIT: begin
          if (u_done) begin
            op <= op_next;
            if ((op == nbg_pkg::OP_SQY && d2_sum == '0) || op == nbg_pkg::OP_DY) begin
              j <= j + CNT_W'(1);
            end
          end
        end
        nbg_pkg::S_WR_I:  i <= i_last ? '0 : i + CNT_W'(1);
        nbg_pkg::S_CM_WR: i <= i + CNT_W'(1);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      treg <= time_step;
      last <= 1'b1;
      case (command)
        nbg_pkg::CMD_ADD: begin
          body_count <= 7'(count);
          body_index <= '0;
          out_pos_x  <= '0;
          out_pos_y  <= '0;
          out_vel_x  <= '0;
          out_vel_y  <= '0;
          if (count == CNT_MAX) begin
            status <= nbg_pkg::ST_FULL;
          end else if (body_mass == '0) begin
            status <= nbg_pkg::ST_ZERO_MASS;
          end else begin
            status     <= nbg_pkg::ST_ADDED;
            body_index <= 6'(count);
            body_count <= 7'(count + CNT_W'(1));
            out_pos_x  <= pos_x;
            out_pos_y  <= pos_y;
            out_vel_x  <= vel_x;
            out_vel_y  <= vel_y;
          end
        end
        nbg_pkg::CMD_CLEAR: begin
          status     <= nbg_pkg::ST_CLEARED;
          body_index <= '0;
          body_count <= '0;
          out_pos_x  <= '0;
          out_pos_y  <= '0;
          out_vel_x  <= '0;
          out_vel_y  <= '0;
        end
        default: ;
      endcase
    end
    case (state)
      nbg_pkg::S_LAT_I: begin
        pix   <= st_rdata[127:96];
        piy   <= st_rdata[95:64];
        vix   <= st_rdata[63:32];
        viy   <= st_rdata[31:0];
        mi    <= at_rdata[32:1];
        fix_i <= at_rdata[0];
        fx    <= '0;
        fy    <= '0;
      end
      nbg_pkg::S_LAT_J: begin
        mj  <= at_rdata[32:1];
        sgx <= dx[32];
        sgy <= dy[32];
        ax  <= dx[32] ? 33'(-dx) : 33'(dx);
        ay  <= dy[32] ? 33'(-dy) : 33'(dy);
      end
      nbg_pkg::S_FIN_I: begin
        if (fix_i) begin
          pnx <= pix;
          pny <= piy;
          vnx <= '0;
          vny <= '0;
        end
      end
      nbg_pkg::S_RUN_WAIT: begin
        if (u_done) begin
          case (op)
            nbg_pkg::OP_SQX: d2 <= u_res[65:0];
            nbg_pkg::OP_SQY: d2 <= d2_sum;
            nbg_pkg::OP_MM:  c  <= u_res[63:0];
            nbg_pkg::OP_MC:  c  <= u_res[79:16];
            nbg_pkg::OP_NX, nbg_pkg::OP_NY, nbg_pkg::OP_FX, nbg_pkg::OP_FY: num <= u_res;
            nbg_pkg::OP_DX:  fx <= nbg_pkg::sat62_add(fx, u_res[62:0], sgx);
            nbg_pkg::OP_DY:  fy <= nbg_pkg::sat62_add(fy, u_res[62:0], sgy);
            nbg_pkg::OP_VX:  vnx <= nbg_pkg::sat32_add(vix, 57'(u_res[40:0]), fx[63]);
            nbg_pkg::OP_VY:  vny <= nbg_pkg::sat32_add(viy, 57'(u_res[40:0]), fy[63]);
            nbg_pkg::OP_PX:  pnx <= nbg_pkg::sat32_add(pix, dp, sx[32]);
            nbg_pkg::OP_PY:  pny <= nbg_pkg::sat32_add(piy, dp, sy[32]);
            default: ;
          endcase
        end
      end
      nbg_pkg::S_CM_WR: begin
        status     <= nbg_pkg::ST_BODY;
        body_index <= 6'(i);
        body_count <= 7'(count);
        last       <= i_last;
        out_pos_x  <= sg_rdata[127:96];
        out_pos_y  <= sg_rdata[95:64];
        out_vel_x  <= sg_rdata[63:32];
        out_vel_y  <= sg_rdata[31:0];
      end
      default: ;
    endcase
  end

  nbg_arith u_arith (
    .clk  (clk),
    .rst  (rst),
    .req  (u_req),
    .a    (u_a),
    .b    (u_b),
    .done (u_done),
    .res  (u_res)
  );

  nbg_ram #(.WIDTH(128), .DEPTH(MAX_BODIES)) u_state_ram (
    .clk(clk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
    .raddr(st_raddr), .rdata(st_rdata)
  );

  nbg_ram #(.WIDTH(33), .DEPTH(MAX_BODIES)) u_attr_ram (
    .clk(clk), .we(at_we), .waddr(at_waddr), .wdata(at_wdata),
    .raddr(at_raddr), .rdata(at_rdata)
  );

  nbg_ram #(.WIDTH(128), .DEPTH(MAX_BODIES)) u_staged_ram (
    .clk(clk), .we(sg_we), .waddr(sg_waddr), .wdata(sg_wdata),
    .raddr(sg_raddr), .rdata(sg_rdata)
  );

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_MAX) else $error("body count past table size");
  a_last_ends_request: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (last != busy)) else $error("last out of step with busy");
  a_unit_done_wait: assert property (@(posedge clk) disable iff (rst)
    u_done |-> state == nbg_pkg::S_RUN_WAIT) else $error("unit done outside wait");
  a_full_reject: assert property (@(posedge clk) disable iff (rst)
    accept && command == nbg_pkg::CMD_ADD && count == CNT_MAX
    |=> result_valid && status == nbg_pkg::ST_FULL) else $error("full table add accepted");

endmodule
`default_nettype wire
